@@ rtl/core/fused_axpy_weighted_dot_core_defines.svh @@
// Assertion macros shared by the fused AXPY / weighted dot core.
`ifndef FUSED_AXPY_WEIGHTED_DOT_CORE_DEFINES_SVH
`define FUSED_AXPY_WEIGHTED_DOT_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk, disabled while rst is high.
`define FAWD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, disabled while rst is high.
`define FAWD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/fawd_pkg.sv @@
// Shared constants, codes and control types of the fused AXPY / weighted dot core.
package fawd_pkg;

  // Default widths of the fixed-point data path
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Accumulator width and multiplier digit width
  localparam int ACC_W   = 64;
  localparam int CHUNK_W = 16;

  // Configuration register indexes
  localparam logic REG_STEP_SCALE = 1'b0;
  localparam logic REG_NORM_MODE  = 1'b1;

  // Multiplier operand selection
  localparam logic [1:0] SEL_SCALE_BASIS = 2'd0;
  localparam logic [1:0] SEL_UPD_OTHER   = 2'd1;
  localparam logic [1:0] SEL_TERM_WEIGHT = 2'd2;

  // Width of the unsigned product magnitude for a given data width
  function automatic int prod_width(input int dw);
    return ACC_W + ((dw + CHUNK_W - 1) / CHUNK_W) * CHUNK_W;
  endfunction

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       capture;
    logic       mul_start;
    logic [1:0] mul_sel;
    logic       post_upd;
    logic       post_prod;
    logic       post_term;
    logic       acc_out;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic mul_done;
    logic out_free;
  } dp_stat_t;

endpackage

@@ rtl/core/fawd_mul.sv @@
// Digit-serial signed multiplier: 64-bit operand times a DATA_WIDTH operand.
module fawd_mul #(
  parameter int DATA_WIDTH = fawd_pkg::DATA_WIDTH_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              start,
  input  logic signed [fawd_pkg::ACC_W-1:0]                 a,
  input  logic signed [DATA_WIDTH-1:0]                      b,
  output logic                                              done,
  output logic signed [fawd_pkg::prod_width(DATA_WIDTH):0]  prod
);
  import fawd_pkg::*;

  localparam int NCH   = (DATA_WIDTH + CHUNK_W - 1) / CHUNK_W;
  localparam int BW    = NCH * CHUNK_W;
  localparam int PW    = prod_width(DATA_WIDTH);
  localparam int CNT_W = $clog2(NCH + 1);

  logic                       run;
  logic                       fin;
  logic [CNT_W-1:0]           cnt;
  logic [ACC_W-1:0]           a_mag;
  logic [BW-1:0]              b_sh;
  logic                       neg;
  logic [PW-1:0]              acc;
  logic [ACC_W-1:0]           a_u;
  logic [ACC_W-1:0]           a_abs;
  logic [DATA_WIDTH-1:0]      b_u;
  logic [DATA_WIDTH-1:0]      b_abs;
  logic [ACC_W+CHUNK_W-1:0]   pp;
  logic [PW:0]                mag_ext;
  logic                       last_chunk;

  // Operand magnitudes
  assign a_u   = a;
  assign b_u   = b;
  assign a_abs = a_u[ACC_W-1] ? (~a_u + ACC_W'(1)) : a_u;
  assign b_abs = b_u[DATA_WIDTH-1] ? (~b_u + DATA_WIDTH'(1)) : b_u;

  // One digit of b per cycle, most significant first
  assign pp         = (ACC_W+CHUNK_W)'(a_mag) * (ACC_W+CHUNK_W)'(b_sh[BW-1 -: CHUNK_W]);
  assign last_chunk = (cnt == CNT_W'(NCH - 1));
  assign mag_ext    = {1'b0, acc};
  assign done       = fin;

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
    end else if (start) begin
      run <= 1'b1;
      fin <= 1'b0;
    end else if (run && last_chunk) begin
      run <= 1'b0;
      fin <= 1'b1;
    end else begin
      fin <= 1'b0;
    end
  end

  // Operand load, shift-and-add, sign fix-up
  always_ff @(posedge clk) begin
    if (start) begin
      a_mag <= a_abs;
      b_sh  <= BW'(b_abs);
      neg   <= a_u[ACC_W-1] ^ b_u[DATA_WIDTH-1];
      acc   <= '0;
      cnt   <= '0;
    end else if (run) begin
      acc  <= (acc << CHUNK_W) + PW'(pp);
      b_sh <= b_sh << CHUNK_W;
      cnt  <= cnt + CNT_W'(1);
    end
    if (fin) begin
      prod <= neg ? (~mag_ext + (PW+1)'(1)) : mag_ext;
    end
  end

endmodule

@@ rtl/core/fawd_datapath.sv @@
// Datapath: item registers, shared multiplier, saturation, accumulator, result register.
module fawd_datapath #(
  parameter int DATA_WIDTH = fawd_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = fawd_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  fawd_pkg::dp_cmd_t                   cmd,
  output fawd_pkg::dp_stat_t                  stat,
  input  logic signed [DATA_WIDTH-1:0]        work_value,
  input  logic signed [DATA_WIDTH-1:0]        basis_value,
  input  logic signed [DATA_WIDTH-1:0]        next_basis_value,
  input  logic        [DATA_WIDTH-2:0]        weight_value,
  input  logic                                last_item,
  input  logic signed [DATA_WIDTH-1:0]        step_scale,
  input  logic                                norm_mode,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [DATA_WIDTH-1:0]        updated_value,
  output logic signed [fawd_pkg::ACC_W-1:0]   dot_sum,
  output logic                                sum_valid
);
  import fawd_pkg::*;

  localparam int PW = prod_width(DATA_WIDTH);
  localparam logic [DATA_WIDTH-1:0] DW_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] DW_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [ACC_W-1:0]      SUM_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0]      SUM_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic signed [DATA_WIDTH-1:0]  work_q;
  logic signed [DATA_WIDTH-1:0]  basis_q;
  logic signed [DATA_WIDTH-1:0]  next_q;
  logic        [DATA_WIDTH-2:0]  weight_q;
  logic                          last_q;
  logic signed [DATA_WIDTH-1:0]  upd_q;
  logic signed [ACC_W-1:0]       p2s_q;
  logic signed [ACC_W-1:0]       term_q;
  logic signed [ACC_W-1:0]       running_sum;

  logic signed [ACC_W-1:0]       mul_a;
  logic signed [DATA_WIDTH-1:0]  mul_b;
  logic                          mul_done;
  logic signed [PW:0]            prod;
  logic signed [PW:0]            shifted;
  logic signed [PW+1:0]          diff;
  logic                          diff_ok;
  logic [DATA_WIDTH-1:0]         upd_sat;
  logic                          wide_ok;
  logic [ACC_W-1:0]              prod_sat;
  logic [ACC_W-1:0]              sum_raw;
  logic                          sum_ovf;
  logic signed [ACC_W-1:0]       sum_next;

  // Select multiplier operands for the current step
  always_comb begin
    unique case (cmd.mul_sel)
      SEL_SCALE_BASIS: begin
        mul_a = ACC_W'(step_scale);
        mul_b = basis_q;
      end
      SEL_UPD_OTHER: begin
        mul_a = ACC_W'(upd_q);
        mul_b = norm_mode ? upd_q : next_q;
      end
      SEL_TERM_WEIGHT: begin
        mul_a = p2s_q;
        mul_b = signed'({1'b0, weight_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  fawd_mul #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  // Truncate the product to the fixed-point scale
  assign shifted = prod >>> FRAC_BITS;

  // Subtract and saturate to the data width
  assign diff    = (PW+2)'(work_q) - (PW+2)'(shifted);
  assign diff_ok = (&diff[PW+1:DATA_WIDTH-1]) | ~(|diff[PW+1:DATA_WIDTH-1]);
  assign upd_sat = diff_ok ? diff[DATA_WIDTH-1:0] : (diff[PW+1] ? DW_MIN : DW_MAX);

  // Saturate the truncated product to the accumulator width
  assign wide_ok  = (&shifted[PW:ACC_W-1]) | ~(|shifted[PW:ACC_W-1]);
  assign prod_sat = wide_ok ? shifted[ACC_W-1:0] : (shifted[PW] ? SUM_MIN : SUM_MAX);

  // Saturating accumulate
  assign sum_raw  = running_sum + term_q;
  assign sum_ovf  = (running_sum[ACC_W-1] == term_q[ACC_W-1]) &&
                    (sum_raw[ACC_W-1] != running_sum[ACC_W-1]);
  assign sum_next = sum_ovf ? (running_sum[ACC_W-1] ? SUM_MIN : SUM_MAX) : sum_raw;

  assign stat.mul_done = mul_done;
  assign stat.out_free = ~out_valid | out_ready;

  // Capture the item and hold intermediate results
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      work_q   <= work_value;
      basis_q  <= basis_value;
      next_q   <= next_basis_value;
      weight_q <= weight_value;
      last_q   <= last_item;
    end
    if (cmd.post_upd) begin
      upd_q <= upd_sat;
    end
    if (cmd.post_prod) begin
      p2s_q <= prod_sat;
    end
    if (cmd.post_term) begin
      term_q <= prod_sat;
    end
    if (cmd.acc_out) begin
      updated_value <= upd_q;
      dot_sum       <= last_q ? sum_next : '0;
      sum_valid     <= last_q;
    end
  end

  // Advance the running sum and the result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.acc_out) begin
        running_sum <= last_q ? '0 : sum_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/fawd_ctrl.sv @@
// Controller: sequences capture, three multiplies, post steps and result load.
module fawd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fawd_pkg::dp_stat_t stat,
  output fawd_pkg::dp_cmd_t  cmd
);
  import fawd_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_START1 = 4'd1;
  localparam logic [3:0] S_WAIT1  = 4'd2;
  localparam logic [3:0] S_POST1  = 4'd3;
  localparam logic [3:0] S_START2 = 4'd4;
  localparam logic [3:0] S_WAIT2  = 4'd5;
  localparam logic [3:0] S_POST2  = 4'd6;
  localparam logic [3:0] S_START3 = 4'd7;
  localparam logic [3:0] S_WAIT3  = 4'd8;
  localparam logic [3:0] S_POST3  = 4'd9;
  localparam logic [3:0] S_ACC    = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.mul_sel   = SEL_SCALE_BASIS;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_START1;
        end
      end
      S_START1: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = SEL_SCALE_BASIS;
        state_next    = S_WAIT1;
      end
      S_WAIT1: begin
        if (stat.mul_done) begin
          state_next = S_POST1;
        end
      end
      S_POST1: begin
        cmd.post_upd = 1'b1;
        state_next   = S_START2;
      end
      S_START2: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = SEL_UPD_OTHER;
        state_next    = S_WAIT2;
      end
      S_WAIT2: begin
        if (stat.mul_done) begin
          state_next = S_POST2;
        end
      end
      S_POST2: begin
        cmd.post_prod = 1'b1;
        state_next    = S_START3;
      end
      S_START3: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = SEL_TERM_WEIGHT;
        state_next    = S_WAIT3;
      end
      S_WAIT3: begin
        if (stat.mul_done) begin
          state_next = S_POST3;
        end
      end
      S_POST3: begin
        cmd.post_term = 1'b1;
        state_next    = S_ACC;
      end
      S_ACC: begin
        // Hold until the result register can take the transaction
        if (stat.out_free) begin
          cmd.acc_out = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/core/fused_axpy_weighted_dot_core.sv @@
// Top level of the fused AXPY / weighted dot core: config registers, controller, datapath.
// The result is loaded once the three multiplies and their post steps are done, and later
// only while the previous result is still not taken.
// A new item is taken only once the previous result is loaded; all three passes of an item
// use the single 16-bit-digit serial multiplier. Sync reset clears config, sum, out_valid.
`include "fused_axpy_weighted_dot_core_defines.svh"

module fused_axpy_weighted_dot_core #(
  parameter int DATA_WIDTH = fawd_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = fawd_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [DATA_WIDTH-1:0]      work_value,
  input  logic signed [DATA_WIDTH-1:0]      basis_value,
  input  logic signed [DATA_WIDTH-1:0]      next_basis_value,
  input  logic        [DATA_WIDTH-2:0]      weight_value,
  input  logic                              last_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [DATA_WIDTH-1:0]      updated_value,
  output logic signed [fawd_pkg::ACC_W-1:0] dot_sum,
  output logic                              sum_valid,
  input  logic                              cfg_write_en,
  input  logic                              cfg_index,
  input  logic        [DATA_WIDTH-1:0]      cfg_data
);
  import fawd_pkg::*;

  logic signed [DATA_WIDTH-1:0] step_scale;
  logic                         norm_mode;
  dp_cmd_t                      cmd;
  dp_stat_t                     stat;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_scale <= '0;
      norm_mode  <= 1'b0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_STEP_SCALE: step_scale <= cfg_data;
        REG_NORM_MODE:  norm_mode  <= cfg_data[0];
      endcase
    end
  end

  fawd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fawd_datapath #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .work_value       (work_value),
    .basis_value      (basis_value),
    .next_basis_value (next_basis_value),
    .weight_value     (weight_value),
    .last_item        (last_item),
    .step_scale       (step_scale),
    .norm_mode        (norm_mode),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .updated_value    (updated_value),
    .dot_sum          (dot_sum),
    .sum_valid        (sum_valid)
  );

  // Checks on controller and datapath cooperation
  `FAWD_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
  `FAWD_ASSERT_NOW(a_no_result_overwrite, cmd.acc_out, stat.out_free, "result overwritten")
  `FAWD_ASSERT_NOW(a_sum_zero_not_last, out_valid && !sum_valid, dot_sum == '0, "sum not zero")

endmodule
